### hw/rtl/lcs_pkg.sv
// Shared types and constants for the longest common substring block.
// Depends on nothing; used by lcs_cell, longest_common_substring, lcs_result_checker and the testbench.
package lcs_pkg;

  localparam int CMD_W = 2;
  localparam int CH_W  = 8;

  // Command codes carried on the input tuser
  localparam logic [CMD_W-1:0] CMD_APPEND_B = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_A   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_END      = 2'd2;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic            push;   // new A byte: update run row
    logic            clear;  // drop B string and runs
    logic            shift;  // move per-cell best one cell toward cell 0
    logic [CH_W-1:0] ch;     // byte for append or push
  } lcs_ctrl_t;

endpackage

### hw/rtl/lcs_cell.sv
// One cell of the match-run chain: one B byte, its run length and its own best run.
// Depends on lcs_pkg.
module lcs_cell
  import lcs_pkg::*;
#(
  parameter int LW = 7,
  parameter int AW = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  lcs_ctrl_t     ctrl_i,
  input  logic          wr_i,        // store ctrl_i.ch as this cell's B byte
  input  logic [AW-1:0] a_idx_i,     // A position one past the pushed byte
  input  logic [LW-1:0] run_left_i,  // left neighbor's run of the previous row
  output logic [LW-1:0] run_o,
  input  logic [LW-1:0] best_len_i,  // right neighbor's best, for the drain
  input  logic [AW-1:0] best_end_i,
  output logic [LW-1:0] best_len_o,
  output logic [AW-1:0] best_end_o
);

  logic [CH_W-1:0] ch_r;
  logic            valid_r;
  logic [LW-1:0]   run_r;
  logic [LW-1:0]   run_nxt;
  logic [LW-1:0]   blen_r;
  logic [AW-1:0]   bend_r;

  always_comb begin
    if (valid_r && (ch_r == ctrl_i.ch)) begin
      run_nxt = LW'(run_left_i + 1'b1);
    end else begin
      run_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_i) begin
      ch_r <= ctrl_i.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      run_r   <= '0;
      blen_r  <= '0;
      bend_r  <= '0;
    end else begin
      if (ctrl_i.clear) begin
        valid_r <= 1'b0;
        run_r   <= '0;
      end else if (wr_i) begin
        valid_r <= 1'b1;
        run_r   <= '0;
      end else if (ctrl_i.push) begin
        run_r <= run_nxt;
      end
      // strict compare keeps the earliest A position per cell
      if (ctrl_i.shift) begin
        blen_r <= best_len_i;
        bend_r <= best_end_i;
      end else if (ctrl_i.push && (run_nxt > blen_r)) begin
        blen_r <= run_nxt;
        bend_r <= a_idx_i;
      end
    end
  end

  assign run_o      = run_r;
  assign best_len_o = blen_r;
  assign best_end_o = bend_r;

endmodule

### hw/rtl/longest_common_substring.sv
// Top level of the longest common substring block: sequencer, cell chain, result register.
// Depends on lcs_pkg and lcs_cell.
//
// Usage:
//   Input stream: in_tuser carries the command, in_tdata the byte. Command
//   append-B stores the byte in the next free cell; push-A broadcasts the byte
//   to all cells, which update their run lengths together; end-job starts the
//   report. Append and push stream at one per cycle while no drain is running.
//   End-job: each cell keeps its own best run; a drain shifts those bests toward
//   cell 0 while a comparator picks the longest, then the earliest A end, then
//   the earliest cell. The result enters the output register as the drain ends;
//   the input stalls for the whole drain.
//   The drain leaves every cell best cleared, so the next job starts fresh.
//   Output stream: one request per end-job. If the receiver stalls, append and
//   push requests still flow; only a further end-job waits until it is taken.
//   Reset (synchronous, rst_n low) empties both strings, all runs and bests,
//   the overflow flag and the output register. Overlong strings are truncated
//   and reported through the overflow bit.
module longest_common_substring
  import lcs_pkg::*;
#(
  parameter int MAX_B = 64,
  parameter int MAX_A = 4096,
  localparam int LW    = $clog2(MAX_B + 1),
  localparam int AW    = $clog2(MAX_A + 1),
  localparam int OUT_W = ((AW + 2 * LW + 1 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [CH_W-1:0]  in_tdata,   // [7:0] ch
  input  logic [CMD_W-1:0] in_tuser,   // [1:0] cmd
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // start_a, match_len, end_b, overflow, zero pad
);

  typedef enum logic {ST_RUN, ST_DRAIN} state_t;

  state_t        st_r;
  logic [LW-1:0] b_count_r;
  logic [AW-1:0] a_count_r;
  logic          ovf_r;
  logic [LW-1:0] swp_r;      // cell index now at the head of the drain
  logic [LW-1:0] acc_len_r;
  logic [AW-1:0] acc_end_a_r;
  logic [LW-1:0] acc_end_b_r;
  logic          out_valid_r;
  logic [AW-1:0] out_start_r;
  logic [LW-1:0] out_len_r;
  logic [LW-1:0] out_end_b_r;
  logic          out_ovf_r;

  logic          in_fire;
  logic          out_fire;
  logic          do_append;
  logic          do_push;
  logic          do_end;
  logic          b_full;
  logic          a_full;
  logic          swp_last;
  logic          better;
  logic [AW-1:0] a_idx;
  lcs_ctrl_t     ctrl;

  // run_w[j+1] is cell j's run; best_*_w[j] is cell j's best, index MAX_B is the zero feed
  logic [LW-1:0] run_w      [MAX_B+1];
  logic [LW-1:0] best_len_w [MAX_B+1];
  logic [AW-1:0] best_end_w [MAX_B+1];

  // Only an end request must wait for a free output register
  assign in_tready = (st_r == ST_RUN) && (!out_valid_r || (in_tuser != CMD_END));
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;

  assign b_full    = (b_count_r == LW'(MAX_B));
  assign a_full    = (a_count_r == AW'(MAX_A));
  assign do_append = in_fire && (in_tuser == CMD_APPEND_B);
  assign do_push   = in_fire && (in_tuser == CMD_PUSH_A);
  assign do_end    = in_fire && (in_tuser == CMD_END);
  assign a_idx     = AW'(a_count_r + 1'b1);
  assign swp_last  = (swp_r == LW'(MAX_B - 1));

  assign ctrl.push  = do_push && !a_full;
  assign ctrl.clear = do_end;
  assign ctrl.shift = (st_r == ST_DRAIN);
  assign ctrl.ch    = in_tdata;

  assign run_w[0]          = '0;
  assign best_len_w[MAX_B] = '0;
  assign best_end_w[MAX_B] = '0;

  for (genvar j = 0; j < MAX_B; j++) begin : g_cell
    logic wr;
    assign wr = do_append && !b_full && (b_count_r == LW'(j));
    lcs_cell #(
      .LW(LW),
      .AW(AW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl_i     (ctrl),
      .wr_i       (wr),
      .a_idx_i    (a_idx),
      .run_left_i (run_w[j]),
      .run_o      (run_w[j+1]),
      .best_len_i (best_len_w[j+1]),
      .best_end_i (best_end_w[j+1]),
      .best_len_o (best_len_w[j]),
      .best_end_o (best_end_w[j])
    );
  end

  // Cells arrive in B order, so a strict compare keeps the earliest cell on a tie
  assign better = (best_len_w[0] > acc_len_r) ||
                  ((best_len_w[0] == acc_len_r) && (best_end_w[0] < acc_end_a_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_RUN;
      b_count_r   <= '0;
      a_count_r   <= '0;
      ovf_r       <= 1'b0;
      swp_r       <= '0;
      acc_len_r   <= '0;
      acc_end_a_r <= '0;
      acc_end_b_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        ST_RUN: begin
          if (do_append) begin
            if (b_full) begin
              ovf_r <= 1'b1;
            end else begin
              b_count_r <= LW'(b_count_r + 1'b1);
            end
          end
          if (do_push) begin
            if (a_full) begin
              ovf_r <= 1'b1;
            end else begin
              a_count_r <= a_idx;
            end
          end
          if (do_end) begin
            st_r        <= ST_DRAIN;
            b_count_r   <= '0;
            a_count_r   <= '0;
            swp_r       <= '0;
            acc_len_r   <= '0;
            acc_end_a_r <= '0;
            acc_end_b_r <= '0;
          end
        end
        ST_DRAIN: begin
          if (better) begin
            acc_len_r   <= best_len_w[0];
            acc_end_a_r <= best_end_w[0];
            acc_end_b_r <= LW'(swp_r + 1'b1);
          end
          swp_r <= LW'(swp_r + 1'b1);
          if (swp_last) begin
            st_r        <= ST_RUN;
            out_valid_r <= 1'b1;
            ovf_r       <= 1'b0;
          end
        end
        default: begin
          st_r <= ST_RUN;
        end
      endcase
    end
  end

  // Result payload, loaded as the drain finishes
  always_ff @(posedge clk) begin
    if ((st_r == ST_DRAIN) && swp_last) begin
      out_ovf_r <= ovf_r;
      if (better) begin
        out_len_r   <= best_len_w[0];
        out_end_b_r <= LW'(swp_r + 1'b1);
        out_start_r <= AW'(best_end_w[0] - AW'(best_len_w[0]));
      end else begin
        out_len_r   <= acc_len_r;
        out_end_b_r <= acc_end_b_r;
        out_start_r <= AW'(acc_end_a_r - AW'(acc_len_r));
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_ovf_r, out_end_b_r, out_len_r, out_start_r});

  // An end request always starts a drain
  a_end_drains: assert property (@(posedge clk) disable iff (!rst_n)
    do_end |=> (st_r == ST_DRAIN))
    else $error("end request did not start the drain");

  // The drain must leave the head cell best cleared for the next job
  a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == ST_DRAIN) && swp_last) |=> (best_len_w[0] == '0))
    else $error("cell bests not cleared after drain");

  // A result appears only at the end of a drain
  a_out_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(st_r) == ST_DRAIN))
    else $error("result raised outside a drain");

  // A match cannot be longer than the B prefix it ends in
  a_len_vs_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_len_r <= out_end_b_r))
    else $error("match length exceeds its B end");

  a_b_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    b_count_r <= LW'(MAX_B))
    else $error("B count beyond store depth");

endmodule

### verif/lcs_result_checker.sv
// Result checker for longest_common_substring: watches both streams, predicts each report.
// Depends on lcs_pkg; instantiated by longest_common_substring_tb beside the block.
module lcs_result_checker
  import lcs_pkg::*;
#(
  parameter int MAX_B = 64,
  parameter int MAX_A = 4096,
  localparam int LW    = $clog2(MAX_B + 1),
  localparam int AW    = $clog2(MAX_A + 1),
  localparam int OUT_W = ((AW + 2 * LW + 1 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [CH_W-1:0]  in_tdata,
  input  logic [CMD_W-1:0] in_tuser,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,
  output int               fail_count,
  output int               pending
);

  typedef struct {
    logic [AW-1:0] start_a;
    logic [LW-1:0] match_len;
    logic [LW-1:0] end_b;
    logic          overflow;
  } lcs_report_t;

  // predicted job state
  logic [CH_W-1:0] b_bytes [MAX_B];
  int unsigned     run_prev [MAX_B];
  int unsigned     b_len, a_len;
  int unsigned     best_len, best_end_a, best_end_b;
  logic            trunc_seen;

  lcs_report_t     reports_due [$];
  int              mismatches = 0;

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic drop_job();
    b_len      = 0;
    a_len      = 0;
    best_len   = 0;
    best_end_a = 0;
    best_end_b = 0;
    trunc_seen = 1'b0;
    foreach (run_prev[j]) run_prev[j] = 0;
  endtask

  // one A byte: new run row against every stored B byte, strict > keeps earliest
  task automatic extend_runs(input logic [CH_W-1:0] c);
    int unsigned row [MAX_B];
    int          j;
    if (a_len >= MAX_A) begin
      trunc_seen = 1'b1;
      return;
    end
    a_len++;
    for (j = 0; j < b_len; j++) begin
      if (b_bytes[j] == c) row[j] = (j == 0) ? 1 : run_prev[j-1] + 1;
      else row[j] = 0;
    end
    for (j = 0; j < b_len; j++) begin
      run_prev[j] = row[j];
      if (row[j] > best_len) begin
        best_len   = row[j];
        best_end_a = a_len;
        best_end_b = j + 1;
      end
    end
  endtask

  task automatic apply_request(input logic [CMD_W-1:0] cmd, input logic [CH_W-1:0] c);
    lcs_report_t r;
    case (cmd)
      CMD_APPEND_B: begin
        if (b_len >= MAX_B) begin
          trunc_seen = 1'b1;
        end else begin
          b_bytes[b_len]  = c;
          run_prev[b_len] = 0;
          b_len++;
        end
      end
      CMD_PUSH_A: extend_runs(c);
      CMD_END: begin
        r.start_a   = AW'(best_end_a - best_len);
        r.match_len = LW'(best_len);
        r.end_b     = LW'(best_end_b);
        r.overflow  = trunc_seen;
        reports_due.push_back(r);
        drop_job();
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    lcs_report_t want;
    if (!rst_n) begin
      drop_job();
      reports_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (reports_due.size() == 0) begin
          flag_mismatch("unexpected report, match_len", int'(out_tdata[AW +: LW]), 0);
        end else begin
          want = reports_due.pop_front();
          if (out_tdata[AW-1:0] !== want.start_a)
            flag_mismatch("start_a", int'(out_tdata[AW-1:0]), int'(want.start_a));
          if (out_tdata[AW +: LW] !== want.match_len)
            flag_mismatch("match_len", int'(out_tdata[AW +: LW]), int'(want.match_len));
          if (out_tdata[AW+LW +: LW] !== want.end_b)
            flag_mismatch("end_b", int'(out_tdata[AW+LW +: LW]), int'(want.end_b));
          if (out_tdata[AW+2*LW] !== want.overflow)
            flag_mismatch("overflow", int'(out_tdata[AW+2*LW]), int'(want.overflow));
        end
      end
      if (in_tvalid && in_tready) apply_request(in_tuser, in_tdata);
    end
    fail_count <= mismatches;
    pending    <= reports_due.size();
  end

endmodule

### verif/longest_common_substring_tb.sv
// Top of the longest_common_substring testbench: clock, reset, request stimulus, verdict.
// Depends on lcs_pkg, longest_common_substring and lcs_result_checker.
module longest_common_substring_tb;
  import lcs_pkg::*;

  localparam int MAX_B = 64;
  localparam int MAX_A = 4096;
  localparam int LW    = $clog2(MAX_B + 1);
  localparam int AW    = $clog2(MAX_A + 1);
  localparam int OUT_W = ((AW + 2 * LW + 1 + 7) / 8) * 8;

  // the one command code the block has no use for; it must be swallowed silently
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // stop adding random jobs once this many meaningful requests went in
  localparam int RANDOM_REQS = 1700;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [CH_W-1:0]  in_tdata   = '0;   // [7:0] ch
  logic [CMD_W-1:0] in_tuser   = '0;   // [1:0] cmd
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;         // start_a, match_len, end_b, overflow, zero pad

  int fail_count;
  int pending;

  // sender burst state, request counter (unused command not counted)
  int burst_left = 0;
  int req_count  = 0;

  // receiver stall pattern state
  int rx_hold = 0;

  always #5 clk = ~clk;

  longest_common_substring #(
    .MAX_B (MAX_B),
    .MAX_A (MAX_A)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  lcs_result_checker #(
    .MAX_B (MAX_B),
    .MAX_A (MAX_A)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Hard stop. The slowest legal run ends well before it, even with
  // the worst sender gaps, receiver stalls and the drain per end request.
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: alternates ready windows and stall windows of random length.
  // Stalls run long compared with the report rate so a report often waits;
  // now and then a long ready window gives a stretch with no back-pressure.
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else if (out_tready) begin
      out_tready <= 1'b0;
      rx_hold    <= $urandom_range(0, 40);
    end else begin
      out_tready <= 1'b1;
      rx_hold    <= ($urandom_range(0, 7) == 0) ? $urandom_range(150, 400)
                                                : $urandom_range(0, 12);
    end
  end

  // One request on the input stream. The sender runs in bursts; once a burst
  // is used up valid drops for a random gap before the next burst starts.
  // Valid stays high through a burst, so back-to-back requests never toggle it.
  task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [CH_W-1:0] c);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                               : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    if (cmd != CMD_UNUSED) req_count++;
  endtask

  // One random job: load B, stream A, usually close with an end request.
  // Small alphabets keep runs frequent; some jobs plant a slice of B inside A
  // so long matches and late-B ties show up. A few jobs skip the end request
  // (strings run together), append B late, or throw in the unused command.
  task automatic run_random_job();
    logic [CH_W-1:0] alph [4];
    logic [CH_W-1:0] b_copy [80];
    logic [CH_W-1:0] c;
    int              b_n, a_n, n_alph, k;
    bit              wide, plant;
    int              plant_at, plant_from;

    k = $urandom_range(0, 19);
    if (k == 0) b_n = 0;
    else if (k == 1) b_n = $urandom_range(MAX_B - 4, MAX_B + 6);
    else b_n = $urandom_range(1, 12);

    k = $urandom_range(0, 19);
    if (k == 0) a_n = 0;
    else if (k == 1) a_n = $urandom_range(40, 80);
    else a_n = $urandom_range(1, 24);

    n_alph = $urandom_range(1, 4);
    foreach (alph[i]) alph[i] = CH_W'($urandom);
    wide  = ($urandom_range(0, 7) == 0);
    plant = ($urandom_range(0, 3) == 0) && (b_n > 0);
    plant_at   = $urandom_range(0, a_n);
    plant_from = (b_n > 0) ? $urandom_range(0, b_n - 1) : 0;

    for (int i = 0; i < b_n; i++) begin
      c = wide ? CH_W'($urandom) : alph[$urandom_range(0, n_alph - 1)];
      b_copy[i] = c;
      send_req(CMD_APPEND_B, c);
    end

    for (int i = 0; i < a_n; i++) begin
      if (plant && i >= plant_at && (i - plant_at + plant_from) < b_n)
        c = b_copy[i - plant_at + plant_from];
      else
        c = wide ? CH_W'($urandom) : alph[$urandom_range(0, n_alph - 1)];
      send_req(CMD_PUSH_A, c);
      // B growing while A is already streaming
      if ($urandom_range(0, 15) == 0)
        send_req(CMD_APPEND_B, alph[$urandom_range(0, n_alph - 1)]);
      if ($urandom_range(0, 19) == 0)
        send_req(CMD_UNUSED, CH_W'($urandom));
    end

    if ($urandom_range(0, 9) != 0) send_req(CMD_END, CH_W'($urandom));
  endtask

  initial begin
    int start_reqs;

    // reset, once
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---
    // end on an empty job: everything zero
    send_req(CMD_END, 8'h00);

    // byte extremes; best run of two ends at the last A byte
    send_req(CMD_APPEND_B, 8'h00);
    send_req(CMD_APPEND_B, 8'hFF);
    send_req(CMD_PUSH_A, 8'hFF);
    send_req(CMD_PUSH_A, 8'h00);
    send_req(CMD_UNUSED, 8'hA5);
    send_req(CMD_PUSH_A, 8'hFF);
    send_req(CMD_END, 8'hFF);

    // A with an empty B never matches
    send_req(CMD_PUSH_A, 8'h41);
    send_req(CMD_PUSH_A, 8'h42);
    send_req(CMD_END, 8'h00);

    // tie: "xy" occurs twice in B, earliest B position must win
    send_req(CMD_APPEND_B, 8'h78);
    send_req(CMD_APPEND_B, 8'h79);
    send_req(CMD_APPEND_B, 8'h78);
    send_req(CMD_APPEND_B, 8'h79);
    send_req(CMD_PUSH_A, 8'h78);
    send_req(CMD_PUSH_A, 8'h79);
    send_req(CMD_END, 8'h00);

    // B byte appended after A started
    send_req(CMD_APPEND_B, 8'h5A);
    send_req(CMD_PUSH_A, 8'h5A);
    send_req(CMD_APPEND_B, 8'h3C);
    send_req(CMD_PUSH_A, 8'h3C);
    send_req(CMD_END, 8'h00);

    // full B plus one dropped byte, A equal to B: run of MAX_B, overflow set
    for (int i = 0; i <= MAX_B; i++) send_req(CMD_APPEND_B, CH_W'(i * 4 + 1));
    for (int i = 0; i < MAX_B; i++) send_req(CMD_PUSH_A, CH_W'(i * 4 + 1));
    send_req(CMD_END, 8'h00);

    // --- random jobs ---
    start_reqs = req_count;
    while (req_count - start_reqs < RANDOM_REQS) run_random_job();
    send_req(CMD_END, 8'h00);
    in_tvalid <= 1'b0;

    // drain: let the checker see the last request, then wait for every report
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (MAX_B + 16) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
